/* design/spi_pkg.sv */
package spi_pkg;

   // Data widths (Q16.16 by default)
   localparam int W         = 32;
   localparam int FRAC_BITS = 16;
   localparam int TOL_W     = 16;
   localparam int DIR_W     = W + 1;
   localparam int PROD_W    = DIR_W + W;
   localparam int DOT_W     = PROD_W + 3;
   localparam int QW        = W;
   localparam int CSR_IDX_W = 3;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NORMAL_X = 3'd0,
      REG_NORMAL_Y = 3'd1,
      REG_NORMAL_Z = 3'd2,
      REG_ANCHOR_X = 3'd3,
      REG_ANCHOR_Y = 3'd4,
      REG_ANCHOR_Z = 3'd5,
      REG_TOL      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_HIT      = 2'd0,
      OUT_PARALLEL = 2'd1,
      OUT_BEFORE   = 2'd2,
      OUT_BEYOND   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [2:0][W-1:0] normal;
      logic [2:0][W-1:0] anchor;
      logic [TOL_W-1:0]  tol;
   } cfg_type;

   typedef struct packed {
      logic [2:0][W-1:0] start;
      logic [2:0][W-1:0] finish;
      logic [W-1:0]      shift;
   } req_type;

   typedef struct packed {
      logic [2:0][W-1:0]     start;
      logic [2:0][DIR_W-1:0] dir;
      logic                  parallel;
      logic                  negq;
      logic                  beyond;
      logic                  ovf;
      logic [DOT_W-1:0]      den_mag;
      logic [DOT_W-1:0]      rem;
      logic [QW-1:0]         qn;
   } div_type;

   typedef struct packed {
      logic              hit;
      outcome_type       outcome;
      logic [W-1:0]      fraction;
      logic [2:0][W-1:0] cross_pt;
   } rsp_type;

   // One restoring division step: numerator bits shift out of the top of qn,
   // quotient bits shift in at the bottom.
   function automatic div_type div_step(div_type d);
      div_type        r;
      logic [DOT_W:0] trial;
      logic [DOT_W:0] diff;
      logic           ge;
      r     = d;
      trial = {d.rem, d.qn[QW-1]};
      diff  = trial - {1'b0, d.den_mag};
      ge    = (trial >= {1'b0, d.den_mag});
      r.rem = ge ? diff[DOT_W-1:0] : trial[DOT_W-1:0];
      r.qn  = {d.qn[QW-2:0], ge};
      return r;
   endfunction

endpackage

/* design/spi_req_if.sv */
interface spi_req_if import spi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] start_x;
   logic signed [W-1:0] start_y;
   logic signed [W-1:0] start_z;
   logic signed [W-1:0] finish_x;
   logic signed [W-1:0] finish_y;
   logic signed [W-1:0] finish_z;
   logic signed [W-1:0] shift;

   modport source (output valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
                   shift, input ready);
   modport sink (input valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
                 shift, output ready);
endinterface

/* design/spi_rsp_if.sv */
interface spi_rsp_if import spi_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [1:0]          outcome;
   logic signed [W-1:0] fraction;
   logic signed [W-1:0] cross_x;
   logic signed [W-1:0] cross_y;
   logic signed [W-1:0] cross_z;

   modport source (output valid, hit, outcome, fraction, cross_x, cross_y, cross_z,
                   input ready);
   modport sink (input valid, hit, outcome, fraction, cross_x, cross_y, cross_z,
                 output ready);
endinterface

/* design/segment_plane_intersection.sv */
// Segment / plane intersection, signed Q16.16 fixed point.
// req_chan carries one segment (start, finish) and a plane shift per
// transaction; rsp_chan returns one result per transaction, in order:
// hit flag, outcome (hit, parallel, before start, beyond end), fraction
// along the segment and the crossing point.
// The plane normal, a point on the plane and the parallel tolerance are
// written through the csr_ port (index 0..6, higher indexes ignored);
// write them only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_chan.ready is high. The
// pipeline holds 4 stages for the dot products, 32 stages of a
// one-bit-per-stage restoring divider, and 3 stages for the crossing
// point and output register.
// Reset clears every stage's valid bit and loads the register defaults
// (normal 0,0,1.0; anchor at origin; tolerance 66). When rsp_chan.ready is
// low, full stages hold; empty stages keep filling, so the input side
// keeps accepting until the pipeline is full.
module segment_plane_intersection import spi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   spi_req_if.sink              req_chan,
   spi_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [W-1:0]         csr_wdata
);

   cfg_type cfg_ff;
   req_type req_data;
   div_type dot_data, div_data;
   rsp_type rsp_data;
   logic    dot_valid, dot_ready, div_valid, div_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal <= {W'(1) << FRAC_BITS, {(2*W){1'b0}}};
         cfg_ff.anchor <= '0;
         cfg_ff.tol    <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NORMAL_X: cfg_ff.normal[0] <= csr_wdata;
            REG_NORMAL_Y: cfg_ff.normal[1] <= csr_wdata;
            REG_NORMAL_Z: cfg_ff.normal[2] <= csr_wdata;
            REG_ANCHOR_X: cfg_ff.anchor[0] <= csr_wdata;
            REG_ANCHOR_Y: cfg_ff.anchor[1] <= csr_wdata;
            REG_ANCHOR_Z: cfg_ff.anchor[2] <= csr_wdata;
            REG_TOL:      cfg_ff.tol       <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_data.start[0]  = req_chan.start_x;
   assign req_data.start[1]  = req_chan.start_y;
   assign req_data.start[2]  = req_chan.start_z;
   assign req_data.finish[0] = req_chan.finish_x;
   assign req_data.finish[1] = req_chan.finish_y;
   assign req_data.finish[2] = req_chan.finish_z;
   assign req_data.shift     = req_chan.shift;

   spi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (dot_valid),
      .out_ready (dot_ready),
      .out_data  (dot_data)
   );

   spi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_ready  (dot_ready),
      .in_data   (dot_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   spi_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.hit      = rsp_data.hit;
   assign rsp_chan.outcome  = rsp_data.outcome;
   assign rsp_chan.fraction = rsp_data.fraction;
   assign rsp_chan.cross_x  = rsp_data.cross_pt[0];
   assign rsp_chan.cross_y  = rsp_data.cross_pt[1];
   assign rsp_chan.cross_z  = rsp_data.cross_pt[2];

endmodule

/* design/spi_dot.sv */
module spi_dot import spi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic [3:0] v_ff;
   logic [4:0] adv;

   // Stage 1: direction and anchor offset
   logic [DIR_W-1:0] dir1_in [3], dir1_ff [3], diff1_in [3], diff1_ff [3];
   logic [W-1:0]     start1_ff [3];
   logic [W-1:0]     shift1_ff;
   // Stage 2: products
   logic signed [PROD_W-1:0] pden2_in [3], pden2_ff [3], pnum2_in [3], pnum2_ff [3];
   logic [W-1:0]     start2_ff [3];
   logic [DIR_W-1:0] dir2_ff [3];
   logic [W-1:0]     shift2_ff;
   // Stage 3: dot products
   logic signed [DOT_W-1:0] den3_in, den3_ff, num3_in, num3_ff;
   logic [W-1:0]     start3_ff [3];
   logic [DIR_W-1:0] dir3_ff [3];
   // Stage 4: magnitudes and classification
   div_type          d4_in, d4_ff;
   logic [DOT_W-1:0] aden, anum, hi_part;

   // Advance a stage when it is empty or its successor moves
   always_comb begin
      adv[4] = out_ready;
      for (int k = 3; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[3];
   assign out_data  = d4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir1_in[i]  = DIR_W'($signed(in_data.finish[i])) - DIR_W'($signed(in_data.start[i]));
         diff1_in[i] = DIR_W'($signed(cfg.anchor[i])) - DIR_W'($signed(in_data.start[i]));
         pden2_in[i] = $signed(dir1_ff[i]) * $signed(cfg.normal[i]);
         pnum2_in[i] = $signed(diff1_ff[i]) * $signed(cfg.normal[i]);
      end
   end

   always_comb begin
      den3_in = DOT_W'(pden2_ff[0]) + DOT_W'(pden2_ff[1]) + DOT_W'(pden2_ff[2]);
      num3_in = DOT_W'(pnum2_ff[0]) + DOT_W'(pnum2_ff[1]) + DOT_W'(pnum2_ff[2])
              + (DOT_W'($signed(shift2_ff)) <<< FRAC_BITS);
   end

   // Classify and seed the divider
   always_comb begin
      aden    = den3_ff[DOT_W-1] ? DOT_W'(-den3_ff) : DOT_W'(den3_ff);
      anum    = num3_ff[DOT_W-1] ? DOT_W'(-num3_ff) : DOT_W'(num3_ff);
      hi_part = anum >> (QW - FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         d4_in.start[i] = start3_ff[i];
         d4_in.dir[i]   = dir3_ff[i];
      end
      d4_in.parallel = (den3_ff == '0) || (aden < (DOT_W'(cfg.tol) << FRAC_BITS));
      d4_in.negq     = (num3_ff != '0) && (num3_ff[DOT_W-1] != den3_ff[DOT_W-1]);
      d4_in.beyond   = anum > aden;
      d4_in.ovf      = hi_part >= aden;
      d4_in.den_mag  = aden;
      d4_in.rem      = hi_part;
      d4_in.qn       = {anum[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < 4; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            dir1_ff[i]   <= dir1_in[i];
            diff1_ff[i]  <= diff1_in[i];
            start1_ff[i] <= in_data.start[i];
         end
         shift1_ff <= in_data.shift;
      end
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            pden2_ff[i]  <= pden2_in[i];
            pnum2_ff[i]  <= pnum2_in[i];
            start2_ff[i] <= start1_ff[i];
            dir2_ff[i]   <= dir1_ff[i];
         end
         shift2_ff <= shift1_ff;
      end
      if (adv[2]) begin
         den3_ff <= den3_in;
         num3_ff <= num3_in;
         for (int i = 0; i < 3; i++) begin
            start3_ff[i] <= start2_ff[i];
            dir3_ff[i]   <= dir2_ff[i];
         end
      end
      if (adv[3]) begin
         d4_ff <= d4_in;
      end
   end

endmodule

/* design/spi_div.sv */
module spi_div import spi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic [QW-1:0] v_ff;
   logic [QW:0]   adv;
   div_type       d_ff [QW];
   div_type       d_in [QW];

   // Advance a stage when it is empty or its successor moves
   always_comb begin
      adv[QW] = out_ready;
      for (int k = QW - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   // One quotient bit per stage
   always_comb begin
      d_in[0] = div_step(in_data);
      for (int k = 1; k < QW; k++) begin
         d_in[k] = div_step(d_ff[k-1]);
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[QW-1];
   assign out_data  = d_ff[QW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < QW; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (adv[k]) d_ff[k] <= d_in[k];
      end
   end

endmodule

/* design/spi_cross.sv */
module spi_cross import spi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

   logic [2:0] v_ff;
   logic [3:0] adv;

   // Stage A: saturate fraction, pick outcome
   logic [W-1:0]     lim, mag, frac_a_in, frac_a_ff;
   outcome_type      oc_a_in, oc_a_ff;
   logic [W-1:0]     start_a_ff [3];
   logic [DIR_W-1:0] dir_a_ff [3];
   // Stage B: scale direction
   logic signed [PROD_W-1:0] p_b_in [3], p_b_ff [3];
   logic [W-1:0]     start_b_ff [3];
   logic [W-1:0]     frac_b_ff;
   outcome_type      oc_b_ff;
   // Stage C: offset, saturate, output register
   logic signed [PROD_W:0] sum_c [3];
   rsp_type          out_c_in, out_c_ff;

   always_comb begin
      adv[3] = out_ready;
      for (int k = 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[2];
   assign out_data  = out_c_ff;

   always_comb begin
      lim = in_data.negq ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      mag = (in_data.ovf || (in_data.qn > lim)) ? lim : in_data.qn;
      if (in_data.parallel) begin
         oc_a_in   = OUT_PARALLEL;
         frac_a_in = '0;
      end else begin
         frac_a_in = in_data.negq ? W'(-mag) : mag;
         if (in_data.negq)        oc_a_in = OUT_BEFORE;
         else if (in_data.beyond) oc_a_in = OUT_BEYOND;
         else                     oc_a_in = OUT_HIT;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_b_in[i] = $signed(dir_a_ff[i]) * $signed(frac_a_ff);
      end
   end

   // Floor by arithmetic shift, then clamp to 32 bits
   always_comb begin
      out_c_in.hit      = (oc_b_ff == OUT_HIT);
      out_c_in.outcome  = oc_b_ff;
      out_c_in.fraction = frac_b_ff;
      for (int i = 0; i < 3; i++) begin
         sum_c[i] = (PROD_W+1)'($signed(start_b_ff[i]))
                  + (PROD_W+1)'(p_b_ff[i] >>> FRAC_BITS);
         if (oc_b_ff != OUT_HIT) begin
            out_c_in.cross_pt[i] = '0;
         end else if (sum_c[i][PROD_W:W-1] == '0 || sum_c[i][PROD_W:W-1] == '1) begin
            out_c_in.cross_pt[i] = sum_c[i][W-1:0];
         end else begin
            out_c_in.cross_pt[i] = sum_c[i][PROD_W] ? {1'b1, {(W-1){1'b0}}}
                                                    : {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         frac_a_ff <= frac_a_in;
         oc_a_ff   <= oc_a_in;
         for (int i = 0; i < 3; i++) begin
            start_a_ff[i] <= in_data.start[i];
            dir_a_ff[i]   <= in_data.dir[i];
         end
      end
      if (adv[1]) begin
         frac_b_ff <= frac_a_ff;
         oc_b_ff   <= oc_a_ff;
         for (int i = 0; i < 3; i++) begin
            p_b_ff[i]     <= p_b_in[i];
            start_b_ff[i] <= start_a_ff[i];
         end
      end
      if (adv[2]) begin
         out_c_ff <= out_c_in;
      end
   end

   // A hit lies on the segment: fraction within [0, 1]
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[2] && out_c_ff.outcome == OUT_HIT) |->
         (!out_c_ff.fraction[W-1] && out_c_ff.fraction <= ONE))
      else $error("hit fraction outside segment");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[2] && out_c_ff.outcome == OUT_PARALLEL) |->
         (out_c_ff.fraction == '0 && out_c_ff.cross_pt == '0))
      else $error("parallel result carries data");

   a_before_sign: assert property (@(posedge clock) disable iff (reset)
      (v_ff[2] && out_c_ff.outcome == OUT_BEFORE) |->
         (out_c_ff.fraction[W-1] || out_c_ff.fraction == '0))
      else $error("before-start fraction positive");

   a_beyond_range: assert property (@(posedge clock) disable iff (reset)
      (v_ff[2] && out_c_ff.outcome == OUT_BEYOND) |->
         (!out_c_ff.fraction[W-1] && out_c_ff.fraction >= ONE))
      else $error("beyond-end fraction below one");

endmodule
